// ===== hdl/bvm_pkg.sv =====
`default_nettype none

package bvm_pkg;

  localparam int unsigned DIV_W  = 32;
  localparam int unsigned DIV_QW = 16;
  localparam int unsigned MV_W   = 16;
  localparam int unsigned PCT_W  = 7;
  localparam int unsigned IDX_W  = 4;

  localparam logic [11:0]      REF_MV    = 12'd3300;
  localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;
  localparam logic [MV_W-1:0]  EMA_DEN   = 16'd5;
  localparam logic [MV_W-1:0]  MV_MAX    = 16'hFFFF;

  localparam logic [IDX_W-1:0] REG_RATIO    = 4'd0;
  localparam logic [IDX_W-1:0] REG_CRITICAL = 4'd1;
  localparam logic [IDX_W-1:0] REG_LOW      = 4'd2;
  localparam logic [IDX_W-1:0] REG_FULL     = 4'd3;

  localparam logic [MV_W-1:0] RATIO_RST    = 16'd8192;
  localparam logic [MV_W-1:0] CRITICAL_RST = 16'd3300;
  localparam logic [MV_W-1:0] LOW_RST      = 16'd3500;
  localparam logic [MV_W-1:0] FULL_RST     = 16'd4200;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_SCALE,
    S_SCALE_DIV,
    S_EMA,
    S_EMA_DIV,
    S_PCT,
    S_PCT_DIV,
    S_OUT
  } state_e;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DIV_QW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              busy;
    logic [DIV_QW-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/bvm_div.sv =====
`default_nettype none

// restoring divider, one quotient bit per cycle; needs dividend[31:16] < divisor
module bvm_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire bvm_pkg::div_req_t req_i,
  output bvm_pkg::div_rsp_t      rsp_o
);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [3:0]                 cnt_q, cnt_d;
  logic [bvm_pkg::DIV_QW-1:0] rem_q, rem_d;
  logic [bvm_pkg::DIV_QW-1:0] quo_q, quo_d;
  logic [bvm_pkg::DIV_QW-1:0] dvs_q, dvs_d;
  logic [bvm_pkg::DIV_QW:0]   trial;
  logic                       ge;

  assign trial = {rem_q, quo_q[bvm_pkg::DIV_QW-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = req_i.dividend[bvm_pkg::DIV_W-1:bvm_pkg::DIV_QW];
      quo_d  = req_i.dividend[bvm_pkg::DIV_QW-1:0];
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? 16'(trial - {1'b0, dvs_q}) : trial[bvm_pkg::DIV_QW-1:0];
      quo_d = {quo_q[bvm_pkg::DIV_QW-2:0], ge};
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd15) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        cnt_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.busy     = busy_q;
  assign rsp_o.quotient = quo_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q)
    else $error("divider done without a running division");

  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> cnt_q == 4'd0)
    else $error("divider step count not cleared when idle");

endmodule

`default_nettype wire

// ===== hdl/battery_voltage_monitor_unit.sv =====
// Battery voltage monitor.
// Input channel: in_valid_i / in_stall_o with adc_sample_i. A transaction is
// taken when valid is high and stall is low; stall stays high while a sample
// is being processed.
// Output channel: out_valid_o / out_stall_i with voltage_mv_o,
// charge_percent_o, is_low_o and is_critical_o; one result per sample. The
// result sits in an output register, so a new sample is taken while it waits.
// Config channel: cfg_valid_i / cfg_ready_o, cfg_index_i, cfg_data_i. Index 0
// divider ratio (Q12), 1 critical level, 2 low level, 3 full level (mV).
// Other indexes are ignored. Write only while the block is idle.
// The next sample is taken only after the previous one has gone to the output
// register. The scaling, the averaging divide by five and the percentage each
// run on one shared restoring divider at one quotient bit per cycle;
// saturated, seeding or clamped cases skip their division.
// Reset: config registers take their defaults and the smoothed voltage is
// cleared, so the first sample seeds the average.
// A stalled result holds; a finished sample waits until the output register
// frees up.
`default_nettype none

module battery_voltage_monitor_unit #(
  parameter int unsigned ADC_BITS = 12
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [ADC_BITS-1:0]          adc_sample_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [bvm_pkg::MV_W-1:0]          voltage_mv_o,
  output logic [bvm_pkg::PCT_W-1:0]         charge_percent_o,
  output logic                              is_low_o,
  output logic                              is_critical_o,
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [bvm_pkg::IDX_W-1:0]    cfg_index_i,
  input  wire logic [bvm_pkg::MV_W-1:0]     cfg_data_i
);

  localparam int unsigned PW = ADC_BITS + 16;
  localparam logic [bvm_pkg::MV_W-1:0] FULL_SCALE = 16'((1 << ADC_BITS) - 1);

  bvm_pkg::state_e state_q, state_d;

  logic [bvm_pkg::MV_W-1:0] ratio_q, crit_q, low_q, full_q;
  logic [ADC_BITS-1:0]      sample_q;
  logic [PW-1:0]            p1_q;
  logic [PW+11:0]           prod;
  logic [bvm_pkg::DIV_W-1:0] num_q;
  logic [bvm_pkg::MV_W-1:0] cur_q;
  logic [bvm_pkg::MV_W-1:0] smoothed_q;
  logic [bvm_pkg::PCT_W-1:0] pct_q;
  logic                     out_valid_q;
  logic [bvm_pkg::MV_W-1:0] out_mv_q;
  logic [bvm_pkg::PCT_W-1:0] out_pct_q;
  logic                     out_low_q, out_crit_q;

  logic                     sat;
  logic                     sm_zero;
  logic                     pct_lo, pct_hi;
  logic [bvm_pkg::DIV_W-1:0] ema_sum;
  logic [bvm_pkg::MV_W-1:0] pct_diff;
  logic [22:0]              pct_prod;
  logic [bvm_pkg::MV_W-1:0] span;
  logic                     in_acc;
  logic                     out_load;

  bvm_pkg::div_req_t div_req;
  bvm_pkg::div_rsp_t div_rsp;

  bvm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_acc   = in_valid_i && !in_stall_o;
  assign prod     = {12'd0, p1_q} * {{PW{1'b0}}, bvm_pkg::REF_MV};
  assign sat      = num_q[bvm_pkg::DIV_W-1:bvm_pkg::DIV_QW] >= FULL_SCALE;
  assign sm_zero  = smoothed_q == '0;
  assign ema_sum  = {14'd0, smoothed_q, 2'b00} + {16'd0, cur_q};
  assign pct_lo   = smoothed_q <= crit_q;
  assign pct_hi   = smoothed_q >= full_q;
  assign pct_diff = smoothed_q - crit_q;
  assign pct_prod = {7'd0, pct_diff} * {16'd0, bvm_pkg::PCT_FULL};
  assign span     = full_q - crit_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bvm_pkg::S_IDLE:      if (in_valid_i) state_d = bvm_pkg::S_MUL1;
      bvm_pkg::S_MUL1:      state_d = bvm_pkg::S_MUL2;
      bvm_pkg::S_MUL2:      state_d = bvm_pkg::S_SCALE;
      bvm_pkg::S_SCALE:     state_d = sat ? bvm_pkg::S_EMA : bvm_pkg::S_SCALE_DIV;
      bvm_pkg::S_SCALE_DIV: if (div_rsp.done) state_d = bvm_pkg::S_EMA;
      bvm_pkg::S_EMA:       state_d = sm_zero ? bvm_pkg::S_PCT : bvm_pkg::S_EMA_DIV;
      bvm_pkg::S_EMA_DIV:   if (div_rsp.done) state_d = bvm_pkg::S_PCT;
      bvm_pkg::S_PCT:       state_d = (pct_lo || pct_hi) ? bvm_pkg::S_OUT
                                                         : bvm_pkg::S_PCT_DIV;
      bvm_pkg::S_PCT_DIV:   if (div_rsp.done) state_d = bvm_pkg::S_OUT;
      bvm_pkg::S_OUT:       if (out_load) state_d = bvm_pkg::S_IDLE;
      default:              state_d = bvm_pkg::S_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_stall_o       = state_q != bvm_pkg::S_IDLE;
    out_load         = (state_q == bvm_pkg::S_OUT) && (!out_valid_q || !out_stall_i);
    div_req.start    = 1'b0;
    div_req.dividend = num_q;
    div_req.divisor  = FULL_SCALE;
    unique case (state_q)
      bvm_pkg::S_SCALE: begin
        div_req.start = !sat;
      end
      bvm_pkg::S_EMA: begin
        div_req.start    = !sm_zero;
        div_req.dividend = ema_sum;
        div_req.divisor  = bvm_pkg::EMA_DEN;
      end
      bvm_pkg::S_PCT: begin
        div_req.start    = !(pct_lo || pct_hi);
        div_req.dividend = {9'd0, pct_prod};
        div_req.divisor  = span;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bvm_pkg::S_IDLE;
      ratio_q     <= bvm_pkg::RATIO_RST;
      crit_q      <= bvm_pkg::CRITICAL_RST;
      low_q       <= bvm_pkg::LOW_RST;
      full_q      <= bvm_pkg::FULL_RST;
      smoothed_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          bvm_pkg::REG_RATIO:    ratio_q <= cfg_data_i;
          bvm_pkg::REG_CRITICAL: crit_q  <= cfg_data_i;
          bvm_pkg::REG_LOW:      low_q   <= cfg_data_i;
          bvm_pkg::REG_FULL:     full_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == bvm_pkg::S_EMA && sm_zero) begin
        smoothed_q <= cur_q;
      end else if (state_q == bvm_pkg::S_EMA_DIV && div_rsp.done) begin
        smoothed_q <= div_rsp.quotient;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) sample_q <= adc_sample_i;
    if (state_q == bvm_pkg::S_MUL1) p1_q <= {16'd0, sample_q} * {{ADC_BITS{1'b0}}, ratio_q};
    if (state_q == bvm_pkg::S_MUL2) num_q <= 32'(prod[PW+11:12]);
    if (state_q == bvm_pkg::S_SCALE && sat) begin
      cur_q <= bvm_pkg::MV_MAX;
    end else if (state_q == bvm_pkg::S_SCALE_DIV && div_rsp.done) begin
      cur_q <= div_rsp.quotient;
    end
    if (state_q == bvm_pkg::S_PCT) begin
      pct_q <= pct_hi && !pct_lo ? bvm_pkg::PCT_FULL : '0;
    end else if (state_q == bvm_pkg::S_PCT_DIV && div_rsp.done) begin
      pct_q <= div_rsp.quotient[bvm_pkg::PCT_W-1:0];
    end
    if (out_load) begin
      out_mv_q   <= smoothed_q;
      out_pct_q  <= pct_q;
      out_low_q  <= smoothed_q < low_q;
      out_crit_q <= smoothed_q < crit_q;
    end
  end

  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign voltage_mv_o     = out_mv_q;
  assign charge_percent_o = out_pct_q;
  assign is_low_o         = out_low_q;
  assign is_critical_o    = out_crit_q;

  a_div_idle_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !div_rsp.busy)
    else $error("sample taken while divider running");

  a_load_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && state_q == bvm_pkg::S_IDLE)
    else $error("result load did not complete the transaction");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_pct_q <= bvm_pkg::PCT_FULL)
    else $error("charge percentage out of range");

endmodule

`default_nettype wire

// ===== tb/sv/tb_battery_voltage_monitor_unit.sv =====
`timescale 1ns / 100ps

module tb_battery_voltage_monitor_unit;

  localparam int unsigned ADC_BITS = 12;
  localparam longint unsigned FULL_SCALE = (64'd1 << ADC_BITS) - 1;
  localparam logic [bvm_pkg::IDX_W-1:0] REG_SPARE = 4'd9;
  localparam int unsigned SETTLE_CYCLES = 70;
  localparam int unsigned TAIL_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PHASES = 8;
  localparam int unsigned ITEMS_PER_PHASE = 118;
  localparam int unsigned PLAN_ROWS = 34;

  typedef struct packed {
    logic [bvm_pkg::MV_W-1:0]  mv;
    logic [bvm_pkg::PCT_W-1:0] pct;
    logic                      low;
    logic                      crit;
  } reading_t;

  typedef enum logic [1:0] {
    ROW_SAMPLE,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e                 kind;
    logic [bvm_pkg::IDX_W-1:0] index;
    logic [bvm_pkg::MV_W-1:0]  data;
    logic                      typed;
    reading_t                  want;
  } plan_row_t;

  localparam reading_t NO_WANT = '0;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic [ADC_BITS-1:0] adc_sample = '0;
  logic out_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic [bvm_pkg::IDX_W-1:0] cfg_index = '0;
  logic [bvm_pkg::MV_W-1:0] cfg_data = '0;

  logic in_stall;
  logic out_valid;
  logic [bvm_pkg::MV_W-1:0] voltage_mv;
  logic [bvm_pkg::PCT_W-1:0] charge_percent;
  logic is_low;
  logic is_critical;
  logic cfg_ready;

  logic [bvm_pkg::MV_W-1:0] cfg_ratio_q12 = bvm_pkg::RATIO_RST;
  logic [bvm_pkg::MV_W-1:0] cfg_critical_mv = bvm_pkg::CRITICAL_RST;
  logic [bvm_pkg::MV_W-1:0] cfg_low_mv = bvm_pkg::LOW_RST;
  logic [bvm_pkg::MV_W-1:0] cfg_full_mv = bvm_pkg::FULL_RST;
  logic [bvm_pkg::MV_W-1:0] avg_mv = '0;

  reading_t pending_readings[$];

  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned results_checked = 0;
  int unsigned samples_sent = 0;
  int unsigned settings_used = 0;
  int unsigned reseeds = 0;
  int unsigned mid_percent = 0;

  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_SAMPLE, bvm_pkg::REG_RATIO, 16'd0, 1'b1, '{16'd0, 7'd0, 1'b1, 1'b1}},
    '{ROW_SAMPLE, bvm_pkg::REG_RATIO, 16'd4095, 1'b1, '{16'd6600, 7'd100, 1'b0, 1'b0}},
    '{ROW_SAMPLE, bvm_pkg::REG_RATIO, 16'd4095, 1'b1, '{16'd6600, 7'd100, 1'b0, 1'b0}},
    '{ROW_SAMPLE, bvm_pkg::REG_RATIO, 16'd2048, 1'b0, NO_WANT},
    '{ROW_SAMPLE, bvm_pkg::REG_RATIO, 16'hAAA, 1'b0, NO_WANT},
    '{ROW_SAMPLE, bvm_pkg::REG_RATIO, 16'h555, 1'b0, NO_WANT},
    '{ROW_CFG, bvm_pkg::REG_RATIO, 16'd65535, 1'b0, NO_WANT},
    '{ROW_SAMPLE, bvm_pkg::REG_RATIO, 16'd4095, 1'b0, NO_WANT},
    '{ROW_SAMPLE, bvm_pkg::REG_RATIO, 16'd4095, 1'b0, NO_WANT},
    '{ROW_CFG, bvm_pkg::REG_RATIO, 16'd4096, 1'b0, NO_WANT},
    '{ROW_SAMPLE, bvm_pkg::REG_RATIO, 16'd1, 1'b0, NO_WANT},
    '{ROW_SAMPLE, bvm_pkg::REG_RATIO, 16'd0, 1'b0, NO_WANT},
    '{ROW_CFG, bvm_pkg::REG_CRITICAL, 16'd0, 1'b0, NO_WANT},
    '{ROW_CFG, bvm_pkg::REG_LOW, 16'd65535, 1'b0, NO_WANT},
    '{ROW_CFG, bvm_pkg::REG_FULL, 16'd65535, 1'b0, NO_WANT},
    '{ROW_SAMPLE, bvm_pkg::REG_RATIO, 16'd4095, 1'b0, NO_WANT},
    '{ROW_SAMPLE, bvm_pkg::REG_RATIO, 16'd2, 1'b0, NO_WANT},
    '{ROW_CFG, bvm_pkg::REG_CRITICAL, 16'd1000, 1'b0, NO_WANT},
    '{ROW_CFG, bvm_pkg::REG_FULL, 16'd1000, 1'b0, NO_WANT},
    '{ROW_CFG, bvm_pkg::REG_LOW, 16'd0, 1'b0, NO_WANT},
    '{ROW_SAMPLE, bvm_pkg::REG_RATIO, 16'd1241, 1'b0, NO_WANT},
    '{ROW_SAMPLE, bvm_pkg::REG_RATIO, 16'd4095, 1'b0, NO_WANT},
    '{ROW_SAMPLE, bvm_pkg::REG_RATIO, 16'd0, 1'b0, NO_WANT},
    '{ROW_CFG, bvm_pkg::REG_CRITICAL, 16'd65535, 1'b0, NO_WANT},
    '{ROW_CFG, bvm_pkg::REG_FULL, 16'd0, 1'b0, NO_WANT},
    '{ROW_SAMPLE, bvm_pkg::REG_RATIO, 16'd3000, 1'b0, NO_WANT},
    '{ROW_CFG, REG_SPARE, 16'hFFFF, 1'b0, NO_WANT},
    '{ROW_SAMPLE, bvm_pkg::REG_RATIO, 16'd100, 1'b0, NO_WANT},
    '{ROW_CFG, bvm_pkg::REG_RATIO, bvm_pkg::RATIO_RST, 1'b0, NO_WANT},
    '{ROW_CFG, bvm_pkg::REG_CRITICAL, bvm_pkg::CRITICAL_RST, 1'b0, NO_WANT},
    '{ROW_CFG, bvm_pkg::REG_LOW, bvm_pkg::LOW_RST, 1'b0, NO_WANT},
    '{ROW_CFG, bvm_pkg::REG_FULL, bvm_pkg::FULL_RST, 1'b0, NO_WANT},
    '{ROW_SAMPLE, bvm_pkg::REG_RATIO, 16'd4095, 1'b0, NO_WANT},
    '{ROW_SAMPLE, bvm_pkg::REG_RATIO, 16'd3103, 1'b0, NO_WANT}
  };

  battery_voltage_monitor_unit #(
    .ADC_BITS(ADC_BITS)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .adc_sample_i    (adc_sample),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .voltage_mv_o    (voltage_mv),
    .charge_percent_o(charge_percent),
    .is_low_o        (is_low),
    .is_critical_o   (is_critical),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Scale, smooth and classify one reading; updates the running average.
  function automatic reading_t battery_reading(input logic [ADC_BITS-1:0] raw);
    longint unsigned scaled;
    int unsigned cur;
    int unsigned mv;
    int unsigned pct;
    reading_t r;
    scaled = (longint'(raw) & FULL_SCALE) * 64'd3300 * longint'(cfg_ratio_q12);
    scaled = scaled / (FULL_SCALE << 12);
    if (scaled > 64'd65535) scaled = 64'd65535;
    cur = int'(scaled);
    if (avg_mv == 0) begin
      mv = cur;
      if (cur != 0) reseeds++;
    end else begin
      mv = (4 * int'(avg_mv) + cur) / 5;
    end
    avg_mv = mv[15:0];
    mv = avg_mv;
    if (mv <= cfg_critical_mv) begin
      pct = 0;
    end else if (mv >= cfg_full_mv) begin
      pct = 100;
    end else begin
      pct = ((mv - cfg_critical_mv) * 100) / (cfg_full_mv - cfg_critical_mv);
      mid_percent++;
    end
    r.mv = mv[15:0];
    r.pct = pct[6:0];
    r.low = (mv < cfg_low_mv);
    r.crit = (mv < cfg_critical_mv);
    return r;
  endfunction

  task automatic send_sample(input logic [ADC_BITS-1:0] raw, input bit typed,
                             input reading_t want);
    int unsigned gap;
    reading_t r;
    gap = 0;
    if (sender_idle_pct != 0) begin
      if ($urandom_range(7) == 0) begin
        gap = $urandom_range(60, 1);
      end else begin
        while ($urandom_range(99) < sender_idle_pct) gap++;
      end
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    adc_sample <= raw;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    r = battery_reading(raw);
    pending_readings.push_back(typed ? want : r);
    samples_sent++;
  endtask

  // Wait until every reading is out and the block has gone quiet.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [bvm_pkg::IDX_W-1:0] idx,
                           input logic [bvm_pkg::MV_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    case (idx)
      bvm_pkg::REG_RATIO:    cfg_ratio_q12 = value;
      bvm_pkg::REG_CRITICAL: cfg_critical_mv = value;
      bvm_pkg::REG_LOW:      cfg_low_mv = value;
      bvm_pkg::REG_FULL:     cfg_full_mv = value;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apply_setting(input int unsigned phase);
    int unsigned ratio;
    int unsigned top_mv;
    int unsigned crit;
    int unsigned low;
    int unsigned full;
    ratio = $urandom_range(65535, 4096);
    case (phase)
      1: ratio = 65535;
      2: ratio = 4096;
      default: ;
    endcase
    top_mv = (3300 * ratio) / 4096;
    crit = $urandom_range(top_mv * 3 / 4, 0);
    full = crit + $urandom_range(top_mv / 2 + 2, 2);
    if (full > 65535) full = 65535;
    low = $urandom_range(full, crit);
    case (phase)
      0: begin
        ratio = bvm_pkg::RATIO_RST;
        crit = bvm_pkg::CRITICAL_RST;
        low = bvm_pkg::LOW_RST;
        full = bvm_pkg::FULL_RST;
      end
      3: begin
        crit = 0;
        low = 0;
        full = 0;
      end
      4: begin
        crit = 65535;
        low = 65535;
        full = 65535;
      end
      5: begin
        full = $urandom_range(top_mv, 0);
        crit = $urandom_range(top_mv, full);
        low = $urandom_range(65535, 0);
      end
      default: ;
    endcase
    drain_block();
    write_reg(bvm_pkg::REG_RATIO, ratio[15:0]);
    write_reg(bvm_pkg::REG_CRITICAL, crit[15:0]);
    write_reg(bvm_pkg::REG_LOW, low[15:0]);
    write_reg(bvm_pkg::REG_FULL, full[15:0]);
    settings_used++;
  endtask

  task automatic random_phase();
    int unsigned n;
    int unsigned kind;
    int unsigned run;
    logic [ADC_BITS-1:0] raw;
    n = 0;
    while (n < ITEMS_PER_PHASE) begin
      kind = $urandom_range(99);
      raw = ADC_BITS'($urandom_range(4095));
      run = 1;
      if (kind < 8) begin
        // long decay so the average reaches zero and reseeds
        raw = '0;
        run = $urandom_range(70, 45);
      end else if (kind < 25) begin
        run = $urandom_range(15, 5);
      end else if (kind < 35) begin
        case ($urandom_range(3))
          0: raw = '0;
          1: raw = 12'd1;
          2: raw = 12'd4094;
          default: raw = 12'd4095;
        endcase
      end
      if (run > ITEMS_PER_PHASE - n) run = ITEMS_PER_PHASE - n;
      repeat (run) send_sample(raw, 1'b0, NO_WANT);
      n += run;
    end
  endtask

  always @(posedge clk_i) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d readings outstanding", cycle_count,
               pending_readings.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected transaction: mv=%0d pct=%0d low=%0b crit=%0b",
                   voltage_mv, charge_percent, is_low, is_critical);
      end else begin
        want = pending_readings.pop_front();
        results_checked++;
        if (voltage_mv !== want.mv || charge_percent !== want.pct ||
            is_low !== want.low || is_critical !== want.crit) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at result %0d: expected mv=%0d pct=%0d low=%0b crit=%0b",
                     results_checked, want.mv, want.pct, want.low, want.crit);
            $display("  got mv=%0d pct=%0d low=%0b crit=%0b",
                     voltage_mv, charge_percent, is_low, is_critical);
          end
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (plan[i].kind == ROW_CFG) begin
        drain_block();
        write_reg(plan[i].index, plan[i].data);
      end else begin
        send_sample(plan[i].data[ADC_BITS-1:0], plan[i].typed, plan[i].want);
      end
    end

    for (int unsigned p = 0; p < PHASES; p++) begin
      sender_idle_pct = 0;
      stall_pct = 0;
      apply_setting(p);
      case (p % 4)
        1: sender_idle_pct = 60;
        2: stall_pct = 60;
        3: begin
          sender_idle_pct = 19;
          stall_pct = 19;
        end
        default: ;
      endcase
      random_phase();
    end

    in_valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d samples sent under %0d register settings, %0d results compared",
             samples_sent, settings_used, results_checked);
    $display("average reseeded %0d times, %0d readings between the levels, %0d mismatches",
             reseeds, mid_percent, mismatches);
    if (mismatches == 0 && pending_readings.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
